// File: src/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while in reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check, also active during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/mbw_pkg.sv
// Types and constants of the MP4 box walker.
// No dependencies; used by mbw_parser, mbw_res_fifo and mp4_box_walker.
package mbw_pkg;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_SKIP,
		PH_TRACK
	} phase_t;

	localparam logic [1:0] EV_BOX   = 2'd0;
	localparam logic [1:0] EV_TRACK = 2'd1;
	localparam logic [1:0] EV_BAD   = 2'd2;
	localparam logic [1:0] EV_END   = 2'd3;

	localparam logic [1:0] ACT_DESCEND = 2'd0;
	localparam logic [1:0] ACT_SKIP    = 2'd1;
	localparam logic [1:0] ACT_PARSE   = 2'd2;

	localparam logic [31:0] FCC_MOOV = {8'h6d, 8'h6f, 8'h6f, 8'h76};
	localparam logic [31:0] FCC_TRAK = {8'h74, 8'h72, 8'h61, 8'h6b};
	localparam logic [31:0] FCC_TKHD = {8'h74, 8'h6b, 8'h68, 8'h64};
	localparam logic [31:0] FCC_MDIA = {8'h6d, 8'h64, 8'h69, 8'h61};
	localparam logic [31:0] FCC_MINF = {8'h6d, 8'h69, 8'h6e, 8'h66};
	localparam logic [31:0] FCC_DINF = {8'h64, 8'h69, 8'h6e, 8'h66};
	localparam logic [31:0] FCC_STBL = {8'h73, 8'h74, 8'h62, 8'h6c};

	localparam logic [31:0] HDR_BYTES = 32'd8;
	localparam logic [31:0] TK_TOTAL  = 32'd92;
	localparam logic [6:0]  HDR_LAST  = 7'd7;
	localparam logic [6:0]  TK_LAST   = 7'd83;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [31:0] box_type;
		logic [31:0] box_length;
		logic [1:0]  box_action;
		logic [31:0] track_number;
		logic [31:0] track_duration;
		logic [31:0] creation_stamp;
		logic [31:0] modify_stamp;
		logic [31:0] track_width;
		logic [31:0] track_height;
		logic [15:0] track_volume;
		logic [7:0]  tkhd_version;
	} result_t;

	// Results produced by one accepted byte; r0 first, r1 only when cnt is 2.
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic logic is_container(input logic [31:0] t);
		return (t == FCC_MOOV) || (t == FCC_TRAK) || (t == FCC_MDIA) ||
			(t == FCC_MINF) || (t == FCC_DINF) || (t == FCC_STBL);
	endfunction

endpackage

// File: src/mbw_parser.sv
// Box walker state and per-byte decode: header gathering, skipping, tkhd fields.
// Depends on mbw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbw_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           acc,
	input  logic [7:0]     data_byte,
	input  logic           last_byte,
	output mbw_pkg::push_t push
);
	import mbw_pkg::*;

	phase_t      phase_q, phase_d;
	logic [6:0]  pos_q, pos_d;
	logic [63:0] hdr_q, hdr_d;
	logic [31:0] skip_q, skip_d;
	logic        halted_q, halted_d;
	logic [31:0] words_q [6];
	logic [31:0] words_n [6];
	logic [15:0] vol_q, vol_d;
	logic [7:0]  ver_q, ver_d;

	logic [63:0] hdr_next;
	logic [31:0] new_size, new_type, cur_size, size_m9, size_m8, size_m92;
	logic        hdr_done, trk_done, ver_bad, vol_hit, size_bad, tkhd_ok, work;
	logic [5:0]  slot_hit;
	logic [6:0]  pos_inc;
	logic        ev_hit;
	logic        idle_state;
	result_t     r_ev, r_end;

	assign work     = acc && !halted_q;
	assign hdr_next = {hdr_q[55:0], data_byte};
	assign new_size = hdr_next[63:32];
	assign new_type = hdr_next[31:0];
	assign cur_size = hdr_q[63:32];
	assign size_m8  = new_size - HDR_BYTES;
	assign size_m9  = cur_size - 32'd9;
	assign size_m92 = cur_size - TK_TOTAL;
	assign size_bad = new_size < HDR_BYTES;
	assign tkhd_ok  = (new_type == FCC_TKHD) && (new_size >= TK_TOTAL);
	assign hdr_done = pos_q == HDR_LAST;
	assign trk_done = pos_q == TK_LAST;
	assign ver_bad  = (pos_q == 7'd0) && (data_byte != 8'd0);
	assign pos_inc  = pos_q + 7'd1;
	assign idle_state = (phase_q == PH_HEADER) && !halted_q && (pos_q == 7'd0);

	// tkhd v0 body offsets: creation, modification, id, duration, width, height
	assign slot_hit[0] = (pos_q >= 7'd4)  && (pos_q < 7'd8);
	assign slot_hit[1] = (pos_q >= 7'd8)  && (pos_q < 7'd12);
	assign slot_hit[2] = (pos_q >= 7'd12) && (pos_q < 7'd16);
	assign slot_hit[3] = (pos_q >= 7'd20) && (pos_q < 7'd24);
	assign slot_hit[4] = (pos_q >= 7'd76) && (pos_q < 7'd80);
	assign slot_hit[5] = (pos_q >= 7'd80) && (pos_q < 7'd84);
	assign vol_hit     = (pos_q == 7'd36) || (pos_q == 7'd37);

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			words_n[i] = (work && phase_q == PH_TRACK && slot_hit[i]) ?
				{words_q[i][23:0], data_byte} : words_q[i];
		end
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		hdr_d    = hdr_q;
		skip_d   = skip_q;
		halted_d = halted_q;
		vol_d    = vol_q;
		ver_d    = ver_q;
		if (work) begin
			case (phase_q)
				PH_SKIP: begin
					skip_d = skip_q - 32'd1;
					if (skip_q == 32'd1)
						phase_d = PH_HEADER;
				end
				PH_TRACK: begin
					if (pos_q == 7'd0)
						ver_d = data_byte;
					if (ver_bad) begin
						pos_d   = 7'd0;
						skip_d  = size_m9;
						phase_d = (size_m9 != 32'd0) ? PH_SKIP : PH_HEADER;
					end else begin
						if (vol_hit)
							vol_d = {vol_q[7:0], data_byte};
						if (trk_done) begin
							pos_d   = 7'd0;
							skip_d  = size_m92;
							phase_d = (size_m92 != 32'd0) ? PH_SKIP : PH_HEADER;
						end else begin
							pos_d = pos_inc;
						end
					end
				end
				default: begin
					hdr_d = hdr_next;
					if (hdr_done) begin
						pos_d = 7'd0;
						if (size_bad) begin
							halted_d = 1'b1;
						end else if (is_container(new_type)) begin
							phase_d = PH_HEADER;
						end else if (tkhd_ok) begin
							phase_d = PH_TRACK;
						end else begin
							skip_d  = size_m8;
							phase_d = (size_m8 != 32'd0) ? PH_SKIP : PH_HEADER;
						end
					end else begin
						pos_d = pos_inc;
					end
				end
			endcase
		end
		if (acc && last_byte) begin
			phase_d  = PH_HEADER;
			pos_d    = 7'd0;
			hdr_d    = '0;
			skip_d   = '0;
			halted_d = 1'b0;
		end
	end

	// results
	always_comb begin
		ev_hit = 1'b0;
		r_ev   = '0;
		r_end  = '0;
		r_end.event_res = EV_END;
		if (work) begin
			case (phase_q)
				PH_TRACK: begin
					r_ev.box_type   = hdr_q[31:0];
					r_ev.box_length = cur_size;
					if (ver_bad) begin
						ev_hit            = 1'b1;
						r_ev.event_res    = EV_BAD;
						r_ev.box_action   = ACT_SKIP;
						r_ev.tkhd_version = data_byte;
					end else if (trk_done) begin
						ev_hit              = 1'b1;
						r_ev.event_res      = EV_TRACK;
						r_ev.box_action     = ACT_PARSE;
						r_ev.creation_stamp = words_n[0];
						r_ev.modify_stamp   = words_n[1];
						r_ev.track_number   = words_n[2];
						r_ev.track_duration = words_n[3];
						r_ev.track_width    = words_n[4];
						r_ev.track_height   = words_n[5];
						r_ev.track_volume   = vol_q;
						r_ev.tkhd_version   = ver_q;
					end
				end
				PH_HEADER: begin
					r_ev.box_type   = new_type;
					r_ev.box_length = new_size;
					if (hdr_done) begin
						ev_hit = 1'b1;
						if (size_bad) begin
							r_ev.event_res  = EV_BAD;
							r_ev.box_action = ACT_SKIP;
						end else if (is_container(new_type)) begin
							r_ev.event_res  = EV_BOX;
							r_ev.box_action = ACT_DESCEND;
						end else if (tkhd_ok) begin
							r_ev.event_res  = EV_BOX;
							r_ev.box_action = ACT_PARSE;
						end else begin
							r_ev.event_res  = EV_BOX;
							r_ev.box_action = ACT_SKIP;
						end
					end
				end
				default: ;
			endcase
		end
		push.r1 = r_end;
		if (ev_hit) begin
			push.r0  = r_ev;
			push.cnt = (acc && last_byte) ? 2'd2 : 2'd1;
		end else begin
			push.r0  = r_end;
			push.cnt = (acc && last_byte) ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= 7'd0;
			hdr_q    <= '0;
			skip_q   <= '0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			hdr_q    <= hdr_d;
			skip_q   <= skip_d;
			halted_q <= halted_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 6; i++)
			words_q[i] <= words_n[i];
		vol_q <= vol_d;
		ver_q <= ver_d;
	end

	`ASSERT_CLK(a_last_clears, (acc && last_byte) |=> idle_state, "state kept after last beat")
	`ASSERT_CLK(a_skip_nonzero, (phase_q == PH_SKIP) |-> (skip_q != 32'd0), "zero skip count")
	`ASSERT_CLK(a_track_pos, (phase_q == PH_TRACK) |-> (pos_q <= TK_LAST), "track position range")

endmodule

// File: src/mbw_res_fifo.sv
// Result queue: takes up to two results per cycle, delivers one per beat.
// Depends on mbw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbw_res_fifo #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mbw_pkg::push_t   push,
	output logic             room2,
	output logic             out_valid,
	input  logic             out_ready,
	output mbw_pkg::result_t rdata
);
	import mbw_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	result_t         mem_q [DEPTH];
	logic [PW-1:0]   wptr_q, rptr_q, wptr_p1;
	logic [CW-1:0]   count_q;
	logic            pop;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wptr_p1   = ptr_inc(wptr_q);
	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign rdata     = mem_q[rptr_q];
	assign room2     = count_q <= CW'(DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			mem_q[wptr_q] <= push.r0;
		if (push.cnt == 2'd2)
			mem_q[wptr_p1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push.cnt == 2'd1)
				wptr_q <= wptr_p1;
			else if (push.cnt == 2'd2)
				wptr_q <= ptr_inc(wptr_p1);
			if (pop)
				rptr_q <= ptr_inc(rptr_q);
			count_q <= count_q + CW'(push.cnt) - CW'(pop);
		end
	end

	`ASSERT_CLK(a_no_overflow, (push.cnt != 2'd0) |-> (count_q + CW'(push.cnt) <= CW'(DEPTH)), "result queue overflow")
	`ASSERT_CLK(a_count_max, count_q <= CW'(DEPTH), "result queue count out of range")
	`ASSERT_CLK(a_pop_count, (pop && push.cnt == 2'd0) |=> (count_q == $past(count_q) - CW'(1)), "pop did not lower count")

endmodule

// File: src/mp4_box_walker.sv
// MP4 box walker: one file byte per input beat, one event per output beat.
// Input channel: in_valid/in_ready with data_byte and last_byte.
// Output channel: out_valid/out_ready with the event fields.
// A byte is decoded in the cycle it is accepted; the result it causes is
// registered in the queue; if it was empty, out_valid rises next cycle.
// Throughput: one byte per cycle while the queue has room for two results.
// Most bytes cause no result; a header end, tkhd end or bad box gives one,
// and a last_byte beat adds an end-of-stream event after it.
// The queue (RES_DEPTH entries) sets how long the input keeps flowing while
// the receiver stalls; in_ready drops once fewer than two slots are free.
// Reset empties the queue and returns the walker to reading a box header.
// Depends on mbw_pkg, mbw_parser, mbw_res_fifo.
module mp4_box_walker #(
	parameter int RES_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  event_res,
	output logic [31:0] box_type,
	output logic [31:0] box_length,
	output logic [1:0]  box_action,
	output logic [31:0] track_number,
	output logic [31:0] track_duration,
	output logic [31:0] creation_stamp,
	output logic [31:0] modify_stamp,
	output logic [31:0] track_width,
	output logic [31:0] track_height,
	output logic [15:0] track_volume,
	output logic [7:0]  tkhd_version
);
	import mbw_pkg::*;

	logic    acc;
	push_t   push;
	result_t rdata;

	assign acc = in_valid && in_ready;

	mbw_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.push      (push)
	);

	mbw_res_fifo #(
		.DEPTH (RES_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rdata     (rdata)
	);

	assign event_res      = rdata.event_res;
	assign box_type       = rdata.box_type;
	assign box_length     = rdata.box_length;
	assign box_action     = rdata.box_action;
	assign track_number   = rdata.track_number;
	assign track_duration = rdata.track_duration;
	assign creation_stamp = rdata.creation_stamp;
	assign modify_stamp   = rdata.modify_stamp;
	assign track_width    = rdata.track_width;
	assign track_height   = rdata.track_height;
	assign track_volume   = rdata.track_volume;
	assign tkhd_version   = rdata.tkhd_version;

endmodule

// File: sim/mp4_box_walker_test.sv
// Self-checking testbench for mp4_box_walker: drives byte streams of MP4 boxes and checks
// every reported event against a cycle-free box walk model kept in this file.
// Depends on mbw_pkg and the mp4_box_walker RTL only.
`timescale 1ns / 1ps

module mp4_box_walker_test;
	import mbw_pkg::*;

	typedef struct {
		logic [7:0] val;
		logic       fin;
	} file_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  event_res;
	logic [31:0] box_type;
	logic [31:0] box_length;
	logic [1:0]  box_action;
	logic [31:0] track_number;
	logic [31:0] track_duration;
	logic [31:0] creation_stamp;
	logic [31:0] modify_stamp;
	logic [31:0] track_width;
	logic [31:0] track_height;
	logic [15:0] track_volume;
	logic [7:0]  tkhd_version;

	mp4_box_walker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_res(event_res),
		.box_type(box_type),
		.box_length(box_length),
		.box_action(box_action),
		.track_number(track_number),
		.track_duration(track_duration),
		.creation_stamp(creation_stamp),
		.modify_stamp(modify_stamp),
		.track_width(track_width),
		.track_height(track_height),
		.track_volume(track_volume),
		.tkhd_version(tkhd_version)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	file_byte_t  pending_bytes[$];
	logic [7:0]  file_bytes[$];
	result_t     expected_events[$];
	file_byte_t  next_byte;

	int fail_count = 0;
	int in_hold = 0;
	int in_calm = 0;
	int out_hold = 0;
	int out_calm = 0;
	bit in_fire = 1'b0;
	bit out_fire = 1'b0;

	// box walk model state
	phase_t      walk_phase;
	logic [6:0]  walk_pos;
	logic [63:0] hdr_window;
	logic [31:0] skip_left;
	logic [31:0] tk_word[6];
	logic [15:0] tk_volume;
	logic [7:0]  tk_version;
	logic        walk_halted;

	function automatic void clear_walker();
		walk_phase = PH_HEADER;
		walk_pos = '0;
		hdr_window = '0;
		skip_left = '0;
		foreach (tk_word[i]) tk_word[i] = '0;
		tk_volume = '0;
		tk_version = '0;
		walk_halted = 1'b0;
	endfunction

	function automatic void post_event(input logic [1:0] ev, input logic [1:0] act,
			input bit with_box, input bit with_track, input logic [7:0] ver);
		result_t r;
		r = '0;
		r.event_res = ev;
		r.box_action = act;
		r.tkhd_version = ver;
		if (with_box) begin
			r.box_type = hdr_window[31:0];
			r.box_length = hdr_window[63:32];
		end
		if (with_track) begin
			r.creation_stamp = tk_word[0];
			r.modify_stamp = tk_word[1];
			r.track_number = tk_word[2];
			r.track_duration = tk_word[3];
			r.track_width = tk_word[4];
			r.track_height = tk_word[5];
			r.track_volume = tk_volume;
		end
		expected_events.push_back(r);
	endfunction

	function automatic void begin_skip(input logic [31:0] n);
		skip_left = n;
		walk_phase = (n != 0) ? PH_SKIP : PH_HEADER;
	endfunction

	function automatic bit holds_boxes(input logic [31:0] t);
		case (t)
			FCC_MOOV, FCC_TRAK, FCC_MDIA, FCC_MINF, FCC_DINF, FCC_STBL: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void header_byte(input logic [7:0] b);
		logic [31:0] sz;
		logic [31:0] ty;
		hdr_window = {hdr_window[55:0], b};
		walk_pos = walk_pos + 7'd1;
		if (walk_pos < 7'd8) return;
		walk_pos = '0;
		sz = hdr_window[63:32];
		ty = hdr_window[31:0];
		if (sz < HDR_BYTES) begin
			post_event(EV_BAD, ACT_SKIP, 1'b1, 1'b0, 8'h00);
			walk_halted = 1'b1;
		end else if (holds_boxes(ty)) begin
			post_event(EV_BOX, ACT_DESCEND, 1'b1, 1'b0, 8'h00);
			walk_phase = PH_HEADER;
		end else if (ty == FCC_TKHD && sz >= TK_TOTAL) begin
			post_event(EV_BOX, ACT_PARSE, 1'b1, 1'b0, 8'h00);
			foreach (tk_word[i]) tk_word[i] = '0;
			tk_volume = '0;
			tk_version = '0;
			walk_phase = PH_TRACK;
		end else begin
			post_event(EV_BOX, ACT_SKIP, 1'b1, 1'b0, 8'h00);
			begin_skip(sz - HDR_BYTES);
		end
	endfunction

	function automatic void track_byte(input logic [7:0] b);
		int p;
		int slot;
		logic [31:0] sz;
		p = int'(walk_pos);
		sz = hdr_window[63:32];
		slot = -1;
		if (p == 0) begin
			tk_version = b;
			if (b != 8'h00) begin
				post_event(EV_BAD, ACT_SKIP, 1'b1, 1'b0, b);
				walk_pos = '0;
				begin_skip(sz - HDR_BYTES - 32'd1);
				return;
			end
		end
		if (p >= 4 && p < 12) slot = (p - 4) / 4;
		else if (p >= 12 && p < 16) slot = 2;
		else if (p >= 20 && p < 24) slot = 3;
		else if (p >= 76 && p < 80) slot = 4;
		else if (p >= 80 && p < 84) slot = 5;
		if (slot >= 0) tk_word[slot] = {tk_word[slot][23:0], b};
		if (p == 36 || p == 37) tk_volume = {tk_volume[7:0], b};
		if (p < int'(TK_LAST)) begin
			walk_pos = 7'(p + 1);
		end else begin
			walk_pos = '0;
			post_event(EV_TRACK, ACT_PARSE, 1'b1, 1'b1, tk_version);
			begin_skip(sz - TK_TOTAL);
		end
	endfunction

	function automatic void walk_byte(input logic [7:0] b, input logic fin);
		if (!walk_halted) begin
			case (walk_phase)
				PH_SKIP: begin
					skip_left = skip_left - 32'd1;
					if (skip_left == 0) walk_phase = PH_HEADER;
				end
				PH_TRACK: track_byte(b);
				default: header_byte(b);
			endcase
		end
		if (fin) begin
			post_event(EV_END, ACT_DESCEND, 1'b0, 1'b0, 8'h00);
			clear_walker();
		end
	endfunction

	function automatic void note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t mismatch %s: expected %h got %h", $time, what, want, got);
	endfunction

	function automatic void check_event();
		result_t want;
		if (expected_events.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t event with nothing pending: event %0d type %h size %h",
					$time, event_res, box_type, box_length);
			return;
		end
		want = expected_events.pop_front();
		if (event_res !== want.event_res)
			note_mismatch("event_res", 32'(want.event_res), 32'(event_res));
		if (box_type !== want.box_type) note_mismatch("box_type", want.box_type, box_type);
		if (box_length !== want.box_length)
			note_mismatch("box_length", want.box_length, box_length);
		if (box_action !== want.box_action)
			note_mismatch("box_action", 32'(want.box_action), 32'(box_action));
		if (track_number !== want.track_number)
			note_mismatch("track_number", want.track_number, track_number);
		if (track_duration !== want.track_duration)
			note_mismatch("track_duration", want.track_duration, track_duration);
		if (creation_stamp !== want.creation_stamp)
			note_mismatch("creation_stamp", want.creation_stamp, creation_stamp);
		if (modify_stamp !== want.modify_stamp)
			note_mismatch("modify_stamp", want.modify_stamp, modify_stamp);
		if (track_width !== want.track_width)
			note_mismatch("track_width", want.track_width, track_width);
		if (track_height !== want.track_height)
			note_mismatch("track_height", want.track_height, track_height);
		if (track_volume !== want.track_volume)
			note_mismatch("track_volume", 32'(want.track_volume), 32'(track_volume));
		if (tkhd_version !== want.tkhd_version)
			note_mismatch("tkhd_version", 32'(want.tkhd_version), 32'(tkhd_version));
	endfunction

	// mostly short gaps, a few long ones, and now and then a calm stretch
	function automatic int draw_idle(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(40, 160);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		out_fire = arst_n && out_valid && out_ready;
		in_fire = arst_n && in_valid && in_ready;
		if (out_fire) check_event();
		if (in_fire) walk_byte(data_byte, last_byte);
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_fire || !in_valid) begin
			if (in_hold > 0) begin
				in_valid <= 1'b0;
				in_hold = in_hold - 1;
			end else if (pending_bytes.size() != 0) begin
				next_byte = pending_bytes.pop_front();
				in_valid <= 1'b1;
				data_byte <= next_byte.val;
				last_byte <= next_byte.fin;
				in_hold = draw_idle(in_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_fire) out_hold = draw_idle(out_calm);
			if (out_hold > 0) begin
				out_ready <= 1'b0;
				out_hold = out_hold - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic put_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--) file_bytes.push_back(w[i*8 +: 8]);
	endtask

	task automatic put_noise(input int n);
		for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// moves the built file into the pending stream, flagging its final beat
	task automatic send_file();
		int n;
		file_byte_t fb;
		if (file_bytes.size() == 0) file_bytes.push_back(8'($urandom_range(0, 255)));
		n = file_bytes.size();
		for (int i = 0; i < n; i++) begin
			fb.val = file_bytes[i];
			fb.fin = (i == n - 1);
			pending_bytes.push_back(fb);
		end
		file_bytes.delete();
	endtask

	function automatic logic [31:0] pick_container();
		case ($urandom_range(0, 5))
			0: return FCC_MOOV;
			1: return FCC_TRAK;
			2: return FCC_MDIA;
			3: return FCC_MINF;
			4: return FCC_DINF;
			default: return FCC_STBL;
		endcase
	endfunction

	function automatic logic [31:0] plain_type();
		if ($urandom_range(0, 3) == 0)
			return pick_container() ^ (32'h1 << $urandom_range(0, 31));
		return $urandom();
	endfunction

	task automatic random_file();
		int boxes;
		int kind;
		int len;
		int tail;
		int keep;
		logic [31:0] sz;
		boxes = $urandom_range(1, 12);
		for (int k = 0; k < boxes; k++) begin
			kind = $urandom_range(0, 99);
			if (kind < 24) begin
				sz = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(8, 600);
				put_word(sz);
				put_word(pick_container());
			end else if (kind < 44) begin
				len = $urandom_range(0, 20);
				put_word(len + 8);
				put_word(plain_type());
				put_noise(len);
			end else if (kind < 58) begin
				tail = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				put_word(TK_TOTAL + tail);
				put_word(FCC_TKHD);
				file_bytes.push_back(8'h00);
				put_noise(83 + tail);
			end else if (kind < 66) begin
				tail = $urandom_range(0, 6);
				put_word(TK_TOTAL + tail);
				put_word(FCC_TKHD);
				file_bytes.push_back(8'($urandom_range(1, 255)));
				put_noise(83 + tail);
			end else if (kind < 73) begin
				len = $urandom_range(0, 83);
				put_word(len + 8);
				put_word(FCC_TKHD);
				put_noise(len);
			end else if (kind < 78) begin
				put_word($urandom_range(0, 7));
				put_word(plain_type());
				put_noise($urandom_range(0, 5));
				break;
			end else if (kind < 88) begin
				put_noise($urandom_range(1, 7));
			end else begin
				put_word($urandom_range(32'h0000_1000, 32'hFFFF_FFFF));
				put_word(plain_type());
				put_noise($urandom_range(0, 12));
				break;
			end
		end
		if (file_bytes.size() > 1 && $urandom_range(0, 6) == 0) begin
			keep = $urandom_range(1, file_bytes.size() - 1);
			while (file_bytes.size() > keep) void'(file_bytes.pop_back());
		end
		send_file();
	endtask

	initial begin : stimulus
		int waited;
		clear_walker();

		// container at minimum size, container at maximum size, header cut by the end
		put_word(32'd8);
		put_word(FCC_MOOV);
		put_word(32'hFFFF_FFFF);
		put_word(FCC_TRAK);
		file_bytes.push_back(8'h00);
		send_file();
		// size below 8 halts the walk until the end beat
		put_word(32'd7);
		put_word(32'hFFFF_FFFF);
		file_bytes.push_back(8'hFF);
		send_file();
		file_bytes.push_back(8'hA5);
		send_file();

		while (pending_bytes.size() < 1450) random_file();

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
		waited = 0;
		while (expected_events.size() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		repeat (16) @(posedge clk);
		if (expected_events.size() != 0) begin
			fail_count++;
			$display("%0d expected events never arrived", expected_events.size());
		end
		if (fail_count == 0)
			$display("[mp4_box_walker] OK");
		else
			$display("[mp4_box_walker] ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[mp4_box_walker] ERROR");
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/mbw_pkg.sv
src/mbw_parser.sv
src/mbw_res_fifo.sv
src/mp4_box_walker.sv
sim/mp4_box_walker_test.sv
